// ===== rtl/core/lmfb_pkg.sv =====
// Shared types and constants for the LED matrix frame buffer and refresh unit.
package lmfb_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STORE_AW    = 5;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIGITS      = WORD_W / DIGIT_W;

  // driver register addresses
  localparam logic [7:0] REG_DECODE    = 8'h09;
  localparam logic [7:0] REG_INTENSITY = 8'h0A;
  localparam logic [7:0] REG_SCANLIMIT = 8'h0B;
  localparam logic [7:0] REG_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] REG_TEST      = 8'h0F;

  localparam logic [3:0] INIT_LAST_FRAME = 4'd4;
  localparam logic [7:0] PIXEL_MSB       = 8'h80;
  localparam logic [7:0] FILL_ON         = 8'hFF;

  typedef enum logic [2:0] {
    OP_SET_PIXEL  = 3'd0,
    OP_GET_PIXEL  = 3'd1,
    OP_WRITE_BYTE = 3'd2,
    OP_READ_BYTE  = 3'd3,
    OP_FILL       = 3'd4,
    OP_REFRESH    = 3'd5,
    OP_INIT       = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_USE,
    S_WREAD,
    S_WLOAD,
    S_WSER,
    S_WOUT
  } state_e;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic                fill;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
    logic [7:0]          fill_val;
  } store_req_t;

  // Startup word for each initialise frame.
  function automatic logic [WORD_W-1:0] init_word(input logic [3:0] frame);
    logic [WORD_W-1:0] w;
    unique case (frame)
      4'd0:    w = {REG_DECODE, 8'h00};
      4'd1:    w = {REG_INTENSITY, 8'h00};
      4'd2:    w = {REG_SCANLIMIT, 8'h07};
      4'd3:    w = {REG_SHUTDOWN, 8'h01};
      default: w = {REG_TEST, 8'h00};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/lmfb_store.sv =====
// Frame store: 32 row bytes, per-entry valid bits, fill by clearing all valid bits.
module lmfb_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lmfb_pkg::store_req_t req_i,
  output logic [7:0]         rd_data_o
);
  import lmfb_pkg::*;

  logic [7:0]             mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_q;
  logic [7:0]             fill_val_q;
  logic [7:0]             rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // invalid entries read as the last fill value (0 after reset)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_val_q <= '0;
    end else if (req_i.fill) begin
      valid_q    <= '0;
      fill_val_q <= req_i.fill_val;
    end else if (req_i.wr_en) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= valid_q[req_i.addr] ? mem_q[req_i.addr] : fill_val_q;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/lmfb_word_ser.sv =====
// Nibble-serial word builder: streams a driver word MSB digit first.
module lmfb_word_ser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lmfb_pkg::WORD_W-1:0] word_i,
  output logic                        busy_o,
  output logic [lmfb_pkg::WORD_W-1:0] word_o
);
  import lmfb_pkg::*;

  localparam int unsigned CW = $clog2(DIGITS);

  logic [WORD_W-1:0] src_q, dst_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DIGITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      src_q <= word_i;
    end else if (busy_q) begin
      src_q <= {src_q[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      dst_q <= {dst_q[WORD_W-DIGIT_W-1:0], src_q[WORD_W-1 -: DIGIT_W]};
    end
  end

  assign busy_o = busy_q;
  assign word_o = dst_q;

endmodule

// ===== rtl/core/led_matrix_frame_buffer_refresh_unit.sv =====
// Top level: host operations on the frame store and chain word sequencer.
// Write byte / fill update the store from the lookup state; set pixel reads there
// and writes back from the use state; get pixel and read byte read there and load
// the output register from the use state, waiting while the output stalls.
// Refresh / initialise: per chain word a read state, a load state, the nibble
// shifts of the word builder and a handoff, waiting while the output stalls;
// NUM_DEVICES*(ROW_COUNT+1) or 5*NUM_DEVICES words. Items are taken only in idle,
// so one item is in flight at a time.
// Reset: store reads dark, intensity register 0, output empty; no sweep.
module led_matrix_frame_buffer_refresh_unit #(
  parameter int NUM_DEVICES = 4,  // 1..4
  parameter int ROW_COUNT   = 8   // 1..8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // host item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row[2:0], column[7:3], value[15:8]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // word[15:0], read_data[23:16]
  output logic [0:0]  m_axis_tuser,   // latch[0]
  output logic        m_axis_tlast,   // last result of the item
  // intensity_per_device write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import lmfb_pkg::*;

  localparam logic [1:0] DEV_MASK = 2'(NUM_DEVICES - 1);
  localparam logic [2:0] ROW_MASK = 3'(ROW_COUNT - 1);
  localparam logic [3:0] REF_LAST_FRAME = 4'(ROW_COUNT);

  state_e state_q, state_d;

  // captured item
  op_e        op_q;
  logic [2:0] row_q;
  logic [4:0] col_q;
  logic [7:0] val_q;

  // word sequencing
  logic [3:0]    frame_q, frame_d;
  logic [1:0]    dev_q, dev_d;
  logic [STORE_AW-1:0] raddr_q, raddr_d;
  logic [15:0]   intens_q;
  logic [15:0]   intens_sh_q, intens_sh_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_word_q, out_word_d;
  logic [7:0]  out_rd_q, out_rd_d;
  logic        out_latch_q, out_latch_d;
  logic        out_last_q, out_last_d;
  logic        out_free;

  store_req_t  req;
  logic [7:0]  rd_data;
  logic        ser_start, ser_busy;
  logic [15:0] ser_in, ser_word;

  logic [1:0]          pdev, bdev;
  logic [STORE_AW-1:0] pix_slot, byte_slot;
  logic [7:0]          pix_mask;
  logic                in_acc, is_ref, dev_last, frame_final;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // address decode; row*N + dev stays below the store depth
  assign pdev      = col_q[4:3] & DEV_MASK;
  assign bdev      = col_q[1:0] & DEV_MASK;
  assign pix_slot  = STORE_AW'(32'(row_q) * NUM_DEVICES + 32'(pdev));
  assign byte_slot = STORE_AW'(32'(row_q) * NUM_DEVICES + 32'(bdev));
  assign pix_mask  = PIXEL_MSB >> col_q[2:0];

  assign is_ref      = (op_q == OP_REFRESH);
  assign dev_last    = (dev_q == DEV_MASK) || (dev_q == 2'(NUM_DEVICES - 1));
  assign frame_final = is_ref ? (frame_q == REF_LAST_FRAME) : (frame_q == INIT_LAST_FRAME);

  lmfb_store u_store (
    .clk_i,
    .rst_ni,
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  lmfb_word_ser u_ser (
    .clk_i,
    .rst_ni,
    .start_i (ser_start),
    .word_i  (ser_in),
    .busy_o  (ser_busy),
    .word_o  (ser_word)
  );

  // item capture and intensity register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_e'(s_axis_tuser);
      row_q <= s_axis_tdata[2:0] & ROW_MASK;
      col_q <= s_axis_tdata[7:3];
      val_q <= s_axis_tdata[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intens_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      intens_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      frame_q     <= '0;
      dev_q       <= '0;
      raddr_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      frame_q     <= frame_d;
      dev_q       <= dev_d;
      raddr_q     <= raddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    intens_sh_q <= intens_sh_d;
    out_word_q  <= out_word_d;
    out_rd_q    <= out_rd_d;
    out_latch_q <= out_latch_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    dev_d       = dev_q;
    raddr_d     = raddr_q;
    intens_sh_d = intens_sh_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_word_d  = out_word_q;
    out_rd_d    = out_rd_q;
    out_latch_d = out_latch_q;
    out_last_d  = out_last_q;
    req         = '0;
    ser_start   = 1'b0;
    ser_in      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          frame_d     = '0;
          dev_d       = '0;
          raddr_d     = '0;
          intens_sh_d = intens_q;
          state_d     = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        state_d = S_IDLE;
        unique case (op_q)
          OP_SET_PIXEL, OP_GET_PIXEL: begin
            req.rd_en = 1'b1;
            req.addr  = pix_slot;
            state_d   = S_USE;
          end
          OP_READ_BYTE: begin
            req.rd_en = 1'b1;
            req.addr  = byte_slot;
            state_d   = S_USE;
          end
          OP_WRITE_BYTE: begin
            req.wr_en = 1'b1;
            req.addr  = byte_slot;
            req.wdata = val_q;
          end
          OP_FILL: begin
            req.fill     = 1'b1;
            req.fill_val = (val_q != 8'd0) ? FILL_ON : 8'd0;
          end
          OP_REFRESH, OP_INIT: state_d = S_WREAD;
          default: state_d = S_IDLE;  // unused code: no effect
        endcase
      end

      // read data of the lookup is now in the store's output register
      S_USE: begin
        if (op_q == OP_SET_PIXEL) begin
          req.wr_en = 1'b1;
          req.addr  = pix_slot;
          req.wdata = (val_q != 8'd0) ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
          state_d   = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '0;
          out_latch_d = 1'b0;
          out_last_d  = 1'b1;
          out_rd_d    = (op_q == OP_GET_PIXEL) ? {7'd0, |(rd_data & pix_mask)} : rd_data;
          state_d     = S_IDLE;
        end
      end

      S_WREAD: begin
        req.rd_en = is_ref && (frame_q != 4'd0);
        req.addr  = raddr_q;
        state_d   = S_WLOAD;
      end

      S_WLOAD: begin
        ser_start = 1'b1;
        if (!is_ref) begin
          ser_in = init_word(frame_q);
        end else if (frame_q == 4'd0) begin
          ser_in = {REG_INTENSITY, 4'd0, intens_sh_q[3:0]};
        end else begin
          ser_in = {4'd0, frame_q, rd_data};
        end
        state_d = S_WSER;
      end

      S_WSER: begin
        if (!ser_busy) begin
          state_d = S_WOUT;
        end
      end

      S_WOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = ser_word;
          out_rd_d    = '0;
          out_latch_d = dev_last;
          out_last_d  = dev_last && frame_final;
          if (is_ref && frame_q == 4'd0) begin
            intens_sh_d = {4'd0, intens_sh_q[15:4]};
          end
          if (is_ref && frame_q != 4'd0) begin
            raddr_d = raddr_q + 1'b1;
          end
          if (dev_last) begin
            dev_d   = '0;
            frame_d = frame_q + 1'b1;
            state_d = frame_final ? S_IDLE : S_WREAD;
          end else begin
            dev_d   = dev_q + 1'b1;
            state_d = S_WREAD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rd_q, out_word_q};
  assign m_axis_tuser  = out_latch_q;
  assign m_axis_tlast  = out_last_q;

  // Word builder runs only while the sequencer waits on it.
  a_ser_in_wser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_busy |-> (state_q == S_WSER))
    else $error("word builder busy outside its wait state");

  // The store never sees a read and a write in the same cycle.
  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.rd_en && req.wr_en))
    else $error("store read and write collide");

  // A frame-ending word never carries read data.
  a_latch_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[23:16] == 8'd0))
    else $error("latch set on a read result");

endmodule
